>>> rtl/arct_pkg.sv
// Package for the aging register cache table: sizes, key layout, item codes
// and the structs passed between the sequencer and the slot unit.
// No dependencies.
package arct_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned KEY_W   = 40;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned AGE_W   = 8;
  localparam int unsigned MODE_W  = 2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_TICK   = 2'd2
  } arct_mode_e;

  // One slot as read by the walk, plus the request key it is checked against.
  typedef struct packed {
    logic [KEY_W-1:0] slot_key;
    logic [AGE_W-1:0] slot_age;
    logic [KEY_W-1:0] req_key;
  } arct_probe_t;

  // Verdict of the shared unit on one slot.
  typedef struct packed {
    logic             free;     // age is zero
    logic             hit;      // live and key matches
    logic [AGE_W-1:0] aged;     // age after one tick
  } arct_verdict_t;

endpackage

>>> rtl/arct_if.sv
// Valid/ready channel interfaces for the request and response beats.
// Depends on arct_pkg.
interface arct_req_if;
  logic                       valid;
  logic                       ready;
  logic [arct_pkg::MODE_W-1:0] mode;
  logic [7:0]                 chain_no;
  logic [7:0]                 chip_no;
  logic [23:0]                reg_ofs;
  logic [arct_pkg::DATA_W-1:0] store_data;
  logic [arct_pkg::AGE_W-1:0]  age;

  modport source (output valid, mode, chain_no, chip_no, reg_ofs, store_data, age,
                  input ready);
  modport sink   (input valid, mode, chain_no, chip_no, reg_ofs, store_data, age,
                  output ready);
endinterface

interface arct_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [arct_pkg::DATA_W-1:0] read_data;

  modport source (output valid, ok, read_data, input ready);
  modport sink   (input valid, ok, read_data, output ready);
endinterface

>>> rtl/aging_register_cache_table.sv
// Aging register cache table, top level: sequencer, slot storage, result register.
// Depends on arct_pkg, arct_if.sv and arct_slot_unit.
//
//  channel | dir | beat carries                                       | accepted when
//  --------+-----+----------------------------------------------------+---------------
//  req_i   | in  | mode, chain_no, chip_no, reg_ofs, store_data, age  | valid & ready
//  rsp_o   | out | ok, read_data                                      | valid & ready
//
// Sequence: a request beat is taken while idle, then the shared slot unit walks the
//   slots in order, then the result is loaded into the output register. Add and
//   lookup stop at the first slot that answers; a tick always walks every slot.
// Reset: all ages clear at once, so every slot is free; keys and data are not
//   reset since a free slot never answers a lookup.
// Stalls: req_i.ready is high only while idle. A result waiting in the output
//   register does not block the next request; the walk holds at its end until
//   the register is free.
module aging_register_cache_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  arct_req_if.sink   req_i,
  arct_rsp_if.source rsp_o
);
  import arct_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_RESULT
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [DATA_W-1:0] wdata_q, wdata_d;
  logic [AGE_W-1:0]  wage_q, wage_d;
  logic              res_ok_q, res_ok_d;
  logic [DATA_W-1:0] res_data_q, res_data_d;
  logic              rsp_valid_q, rsp_valid_d;
  logic              rsp_ok_q, rsp_ok_d;
  logic [DATA_W-1:0] rsp_data_q, rsp_data_d;

  // Slot storage; only ages need reset.
  logic [AGE_W-1:0]  age_q [ENTRIES];
  logic [KEY_W-1:0]  key_mem_q [ENTRIES];
  logic [DATA_W-1:0] data_mem_q [ENTRIES];

  logic              age_we;
  logic [AGE_W-1:0]  age_wval;
  logic              slot_we;     // key/data write on add

  arct_probe_t   probe;
  arct_verdict_t verdict;
  logic          rsp_free;
  logic          req_take;

  assign probe.slot_key = key_mem_q[idx_q];
  assign probe.slot_age = age_q[idx_q];
  assign probe.req_key  = key_q;

  arct_slot_unit u_slot (
    .probe_i   (probe),
    .verdict_o (verdict)
  );

  assign req_i.ready     = (state_q == ST_IDLE);
  assign req_take        = req_i.valid && req_i.ready;
  assign rsp_free        = !rsp_valid_q || rsp_o.ready;
  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.ok        = rsp_ok_q;
  assign rsp_o.read_data = rsp_data_q;

  // Sequencer: one slot a cycle through the shared unit.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    mode_d      = mode_q;
    key_d       = key_q;
    wdata_d     = wdata_q;
    wage_d      = wage_q;
    res_ok_d    = res_ok_q;
    res_data_d  = res_data_q;
    rsp_valid_d = rsp_valid_q;
    rsp_ok_d    = rsp_ok_q;
    rsp_data_d  = rsp_data_q;
    age_we      = 1'b0;
    age_wval    = '0;
    slot_we     = 1'b0;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_take) begin
          mode_d     = req_i.mode;
          key_d      = {req_i.chain_no, req_i.chip_no, req_i.reg_ofs};
          wdata_d    = req_i.store_data;
          wage_d     = req_i.age;
          idx_d      = '0;
          res_ok_d   = 1'b0;
          res_data_d = '0;
          state_d    = ST_WALK;
        end
      end
      ST_WALK: begin
        case (mode_q)
          MODE_ADD: begin
            if (verdict.free) begin
              slot_we  = 1'b1;
              age_we   = 1'b1;
              age_wval = wage_q;
              res_ok_d = 1'b1;
              state_d  = ST_RESULT;
            end else if (idx_q == LAST_IDX) begin
              state_d = ST_RESULT;
            end
          end
          MODE_LOOKUP: begin
            if (verdict.hit) begin
              age_we     = 1'b1;
              age_wval   = '0;
              res_ok_d   = 1'b1;
              res_data_d = data_mem_q[idx_q];
              state_d    = ST_RESULT;
            end else if (idx_q == LAST_IDX) begin
              state_d = ST_RESULT;
            end
          end
          MODE_TICK: begin
            age_we   = 1'b1;
            age_wval = verdict.aged;
            res_ok_d = 1'b1;
            if (idx_q == LAST_IDX) begin
              state_d = ST_RESULT;
            end
          end
          default: begin
            // unused code: no change, ok low
            state_d = ST_RESULT;
          end
        endcase
        if (idx_q != LAST_IDX) begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_RESULT: begin
        if (rsp_free) begin
          rsp_valid_d = 1'b1;
          rsp_ok_d    = res_ok_q;
          rsp_data_d  = res_data_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      mode_q      <= '0;
      key_q       <= '0;
      wdata_q     <= '0;
      wage_q      <= '0;
      res_ok_q    <= 1'b0;
      res_data_q  <= '0;
      rsp_valid_q <= 1'b0;
      rsp_ok_q    <= 1'b0;
      rsp_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      mode_q      <= mode_d;
      key_q       <= key_d;
      wdata_q     <= wdata_d;
      wage_q      <= wage_d;
      res_ok_q    <= res_ok_d;
      res_data_q  <= res_data_d;
      rsp_valid_q <= rsp_valid_d;
      rsp_ok_q    <= rsp_ok_d;
      rsp_data_q  <= rsp_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= '0;
      end
    end else if (age_we) begin
      age_q[idx_q] <= age_wval;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      key_mem_q[idx_q]  <= key_q;
      data_mem_q[idx_q] <= wdata_q;
    end
  end

`ifndef NO_ASSERTIONS
  // A taken beat always starts a walk.
  a_take_walks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_take |=> (state_q == ST_WALK))
    else $error("accepted request did not start a walk");

  // Data only ever leaves with a hit.
  a_data_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (rsp_ok_q || (rsp_data_q == '0)))
    else $error("read data without ok");

  // Slot writes only happen during a walk.
  a_write_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (age_we || slot_we) |-> (state_q == ST_WALK))
    else $error("slot written outside a walk");

  // A result loads the output register only when it is free.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT && rsp_valid_q && !rsp_o.ready) |=> $stable(rsp_data_q))
    else $error("pending response overwritten");
`endif

endmodule

>>> rtl/arct_slot_unit.sv
// Shared per-slot unit: key compare, free test and age decrement.
// Depends on arct_pkg.
module arct_slot_unit (
  input  arct_pkg::arct_probe_t   probe_i,
  output arct_pkg::arct_verdict_t verdict_o
);
  import arct_pkg::*;

  logic live;

  assign live              = (probe_i.slot_age != '0);
  assign verdict_o.free    = !live;
  assign verdict_o.hit     = live && (probe_i.slot_key == probe_i.req_key);
  assign verdict_o.aged    = live ? (probe_i.slot_age - AGE_W'(1)) : '0;

endmodule

>>> dv/tb_aging_register_cache_table.sv
// Self-checking bench for aging_register_cache_table: directed and random request beats.
// Uses arct_pkg, the channel interfaces in arct_if.sv and the RTL top level.
// It keeps its own copy of the slot table, drives randomly gapped beats and checks each answer.
module tb_aging_register_cache_table;
  timeunit 1ns;
  timeprecision 1ps;

  import arct_pkg::*;

  // Mode value three has no enum member; the block must answer it with zeros.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int RAND_ITEMS  = 1650;
  localparam int PHASE1_AT   = 570;    // beats taken before the idling pattern swaps
  localparam int PHASE2_AT   = 1120;   // beats taken before idling stops
  localparam int HOLD_CYCLES = 300;    // long receiver hold-off, fills the block
  // Worst gap with nothing accepted: the hold-off plus a full walk,
  // with plenty of margin for long random idle runs.
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 4 * (ENTRIES + 2);
  localparam int MAX_REPORTS = 60;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [7:0]        chain_no;
    logic [7:0]        chip_no;
    logic [23:0]       reg_ofs;
    logic [DATA_W-1:0] store_data;
    logic [AGE_W-1:0]  age;
  } cache_req_t;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] read_data;
  } cache_answer_t;

  // Flavours of random stretch; each biases the mix of operations.
  typedef enum int {SEG_FILL, SEG_DRAIN, SEG_AGE, SEG_MIX} seg_kind_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  arct_req_if req ();
  arct_rsp_if rsp ();

  aging_register_cache_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow of the slot table, updated as each request beat is taken.
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0]  slot_key  [ENTRIES];
  logic [DATA_W-1:0] slot_data [ENTRIES];
  logic [AGE_W-1:0]  slot_age  [ENTRIES];

  int n_stored, n_full, n_hit, n_miss, n_tick, n_unused;

  // Applies one request to the shadow table and returns the answer it must produce.
  function automatic cache_answer_t table_apply(cache_req_t r);
    cache_answer_t    a;
    logic [KEY_W-1:0] k;
    bit               done;
    a    = '0;
    k    = {r.chain_no, r.chip_no, r.reg_ofs};
    done = 1'b0;
    case (r.mode)
      MODE_ADD: begin
        // first free slot takes it; an age of zero leaves the slot free
        for (int i = 0; i < ENTRIES; i++) begin
          if (!done && slot_age[i] == '0) begin
            slot_key[i]  = k;
            slot_data[i] = r.store_data;
            slot_age[i]  = r.age;
            done         = 1'b1;
          end
        end
        a.ok = done;
        if (done) n_stored++;
        else n_full++;
      end
      MODE_LOOKUP: begin
        // lowest live slot with the key answers and is freed
        for (int i = 0; i < ENTRIES; i++) begin
          if (!done && slot_age[i] != '0 && slot_key[i] == k) begin
            slot_age[i] = '0;
            a.read_data = slot_data[i];
            done        = 1'b1;
          end
        end
        a.ok = done;
        if (done) n_hit++;
        else n_miss++;
      end
      MODE_TICK: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_age[i] != '0) slot_age[i] = slot_age[i] - 1'b1;
        end
        a.ok = 1'b1;
        n_tick++;
      end
      default: n_unused++;
    endcase
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus store and run-wide bookkeeping.
  // ---------------------------------------------------------------------------
  cache_req_t    request_q[$];
  cache_answer_t answer_q[$];
  int            n_items;
  int            n_taken;
  int            n_answered;
  int            n_errors;
  int            phase;        // 0: sender 27 / receiver 81, 1: swapped, 2: no idling
  int            quiet_cycles;
  logic          req_fire;     // request beat taken at the last rising edge

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      slot_key[i]  = '0;
      slot_data[i] = '0;
      slot_age[i]  = '0;
    end
    n_taken      = 0;
    n_answered   = 0;
    n_errors     = 0;
    phase        = 0;
    quiet_cycles = 0;
    req_fire     = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Rising edge: take request beats into the shadow, check answer beats.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cache_req_t    r;
    cache_answer_t want;
    if (rst_ni) begin
      req_fire <= req.valid && req.ready;
      if (req.valid && req.ready) begin
        r.mode       = req.mode;
        r.chain_no   = req.chain_no;
        r.chip_no    = req.chip_no;
        r.reg_ofs    = req.reg_ofs;
        r.store_data = req.store_data;
        r.age        = req.age;
        answer_q.push_back(table_apply(r));
        n_taken++;
      end
      if (rsp.valid && rsp.ready) begin
        n_answered++;
        if (answer_q.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: answer beat with none outstanding: want none, got ok=%0b data=%08h",
                     $realtime, rsp.ok, rsp.read_data);
        end else begin
          want = answer_q.pop_front();
          if (rsp.ok !== want.ok) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("%0t: ok mismatch: want %0b, got %0b", $realtime, want.ok, rsp.ok);
          end
          if (rsp.read_data !== want.read_data) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("%0t: read_data mismatch: want %08h, got %08h",
                       $realtime, want.read_data, rsp.read_data);
          end
        end
      end
      // idling pattern follows the number of beats taken so far
      phase <= (n_taken < PHASE1_AT) ? 0 : (n_taken < PHASE2_AT) ? 1 : 2;
      // watchdog: cycles in a row with no beat on either side
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d of %0d requests taken, %0d answers",
                 $realtime, quiet_cycles, n_taken, n_items, n_answered);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: falling edge, pops the next request once the last one was taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    cache_req_t r;
    int         gap_pct;
    gap_pct = (phase == 0) ? 27 : (phase == 1) ? 81 : 0;
    if (!rst_ni) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req_fire) begin
      if (request_q.size() > 0 && $urandom_range(99) >= gap_pct) begin
        r = request_q.pop_front();
        req.mode       <= r.mode;
        req.chain_no   <= r.chain_no;
        req.chip_no    <= r.chip_no;
        req.reg_ofs    <= r.reg_ofs;
        req.store_data <= r.store_data;
        req.age        <= r.age;
        req.valid      <= 1'b1;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: falling edge, random back-pressure plus one long hold-off at the
  // start of the no-idle phase, so the result register and the walk back up
  // and the block drops req ready while the driver keeps offering.
  // ---------------------------------------------------------------------------
  int hold_left;
  bit hold_done;

  always @(negedge clk_i) begin
    int stall_pct;
    stall_pct = (phase == 0) ? 81 : (phase == 1) ? 27 : 0;
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      rsp.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (phase == 2 && !hold_done) begin
      rsp.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation.
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0] recent_keys[$];   // keys added lately, so lookups can hit

  task automatic queue_req(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k,
                           input logic [DATA_W-1:0] d, input logic [AGE_W-1:0] a);
    cache_req_t r;
    r.mode       = m;
    r.chain_no   = k[39:32];
    r.chip_no    = k[31:24];
    r.reg_ofs    = k[23:0];
    r.store_data = d;
    r.age        = a;
    request_q.push_back(r);
  endtask

  function automatic logic [KEY_W-1:0] fresh_key();
    return {8'($urandom), 32'($urandom)};
  endfunction

  // Mostly short lives so ticks expire slots; some zero, some at the top.
  function automatic logic [AGE_W-1:0] pick_age(seg_kind_e kind);
    int r;
    r = $urandom_range(99);
    if (kind == SEG_FILL && r < 70) return AGE_W'($urandom_range(100, 255));
    r = $urandom_range(99);
    if (r < 6)  return '0;
    if (r < 45) return AGE_W'($urandom_range(1, 3));
    if (r < 80) return AGE_W'($urandom_range(4, 30));
    if (r < 90) return '1;
    return AGE_W'($urandom);
  endfunction

  function automatic logic [KEY_W-1:0] pick_lookup_key();
    int               r;
    logic [KEY_W-1:0] k;
    r = $urandom_range(99);
    if (recent_keys.size() == 0 || r >= 85) return fresh_key();
    k = recent_keys[$urandom_range(recent_keys.size() - 1)];
    // near miss: one key bit off
    if (r >= 70) k[$urandom_range(KEY_W - 1)] ^= 1'b1;
    return k;
  endfunction

  initial begin
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] dup_key;
    seg_kind_e        kind;
    int               seg_len;
    int               n_rand;
    int               r;
    int               add_to, lookup_to, tick_to;

    // all block inputs known from time zero
    rst_ni         = 1'b0;
    req.valid      = 1'b0;
    req.mode       = MODE_ADD;
    req.chain_no   = '0;
    req.chip_no    = '0;
    req.reg_ofs    = '0;
    req.store_data = '0;
    req.age        = '0;
    rsp.ready      = 1'b0;

    // --- directed part ---
    // lookup on an empty table, key equal to the cleared keys: must miss
    queue_req(MODE_LOOKUP, '0, '0, '0);
    // add with age zero: written but the slot stays free, so the lookup misses
    queue_req(MODE_ADD, '0, '1, '0);
    queue_req(MODE_LOOKUP, '0, '0, '0);
    // all-ones key twice: the lower slot answers first
    queue_req(MODE_ADD, '1, '1, '1);
    queue_req(MODE_ADD, '1, 32'hA5A5_5A5A, 8'd1);
    queue_req(MODE_LOOKUP, '1, '0, '0);
    // the tick expires the second copy, so the next lookup misses
    queue_req(MODE_TICK, '1, '1, '1);
    queue_req(MODE_LOOKUP, '1, '1, '1);
    queue_req(MODE_ADD, 40'h80_01_800001, '0, 8'd2);
    queue_req(MODE_ADD, '0, 32'h1234_5678, '1);
    // unused mode carrying all-ones fields: nothing changes
    queue_req(MODE_UNUSED, '1, '1, '1);
    queue_req(MODE_TICK, '0, '0, '0);
    queue_req(MODE_LOOKUP, '0, '1, '1);
    // hit on stored zero data: ok high, data zero
    queue_req(MODE_LOOKUP, 40'h80_01_800001, '0, '0);
    // same key in two slots, consumed one after the other, then gone
    dup_key = 40'h5A_C3_0F00F0;
    queue_req(MODE_ADD, dup_key, 32'hDEAD_0001, 8'd3);
    queue_req(MODE_ADD, dup_key, 32'hDEAD_0002, 8'd4);
    queue_req(MODE_LOOKUP, dup_key, '0, '0);
    queue_req(MODE_LOOKUP, dup_key, '0, '0);
    queue_req(MODE_LOOKUP, dup_key, '0, '0);
    // the key half of all-ones must not alias with a near neighbour
    queue_req(MODE_ADD, 40'h7F_FF_FFFFFF, 32'h0000_0001, 8'd128);
    queue_req(MODE_LOOKUP, '1, '0, '0);
    queue_req(MODE_LOOKUP, 40'h7F_FF_FFFFFF, '0, '0);

    // --- random part: stretches of fill, drain, ageing or mixed traffic ---
    n_rand = 0;
    kind   = SEG_FILL;   // start by filling, so a full table turns up early
    while (n_rand < RAND_ITEMS) begin
      seg_len = (n_rand == 0) ? 40 : $urandom_range(8, 40);
      case (kind)
        SEG_FILL:  begin add_to = 85; lookup_to = 95; tick_to = 99; end
        SEG_DRAIN: begin add_to = 10; lookup_to = 90; tick_to = 98; end
        SEG_AGE:   begin add_to = 35; lookup_to = 55; tick_to = 98; end
        default:   begin add_to = 40; lookup_to = 80; tick_to = 97; end
      endcase
      for (int j = 0; j < seg_len && n_rand < RAND_ITEMS; j++) begin
        r = $urandom_range(99);
        if (r < add_to) begin
          // some re-adds of recent keys give live duplicates
          if (recent_keys.size() > 0 && $urandom_range(99) < 30)
            k = recent_keys[$urandom_range(recent_keys.size() - 1)];
          else
            k = fresh_key();
          recent_keys.push_back(k);
          if (recent_keys.size() > 24) void'(recent_keys.pop_front());
          queue_req(MODE_ADD, k, $urandom, pick_age(kind));
        end else if (r < lookup_to) begin
          queue_req(MODE_LOOKUP, pick_lookup_key(), $urandom, AGE_W'($urandom));
        end else if (r < tick_to) begin
          queue_req(MODE_TICK, fresh_key(), $urandom, AGE_W'($urandom));
        end else begin
          queue_req(MODE_UNUSED, fresh_key(), $urandom, AGE_W'($urandom));
        end
        n_rand++;
      end
      kind = seg_kind_e'($urandom_range(3));
    end
    n_items = request_q.size();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // every request taken, every answer back, then a quiet spell for strays
    while (n_taken < n_items) @(posedge clk_i);
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Ran %0d requests: %0d adds stored, %0d refused on a full table,",
             n_items, n_stored, n_full);
    $display("  %0d lookup hits, %0d misses, %0d ticks, %0d unused-mode beats, %0d errors",
             n_hit, n_miss, n_tick, n_unused, n_errors);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/arct_pkg.sv
rtl/arct_if.sv
rtl/arct_slot_unit.sv
rtl/aging_register_cache_table.sv
dv/tb_aging_register_cache_table.sv
